/* rtl/i2p_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, codes and character tables for the infix to postfix unit.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_ADD   = 8'h2b;
  localparam logic [7:0] CH_SUB   = 8'h2d;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_POW   = 8'h5e;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_POW  = 3'd6,
    OP_NONE = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_UNMATCHED_CLOSE = 3'd1,
    ST_OVERFLOW       = 3'd2,
    ST_UNKNOWN_CHAR   = 3'd3,
    ST_UNMATCHED_OPEN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CLS_SPACE   = 3'd0,
    CLS_ALNUM   = 3'd1,
    CLS_OPEN    = 3'd2,
    CLS_CLOSE   = 3'd3,
    CLS_OPER    = 3'd4,
    CLS_UNKNOWN = 3'd5
  } cls_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    op_e  code;
  } stack_cmd_t;

  function automatic op_e op_code(input logic [7:0] c);
    op_e r;
    case (c)
      CH_ADD:  r = OP_ADD;
      CH_SUB:  r = OP_SUB;
      CH_MUL:  r = OP_MUL;
      CH_DIV:  r = OP_DIV;
      CH_MOD:  r = OP_MOD;
      CH_POW:  r = OP_POW;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic cls_e char_class(input logic [7:0] c);
    cls_e r;
    if (c == CH_SPACE) begin
      r = CLS_SPACE;
    end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
                 (c >= 8'h61 && c <= 8'h7a)) begin
      r = CLS_ALNUM;
    end else if (c == CH_OPEN) begin
      r = CLS_OPEN;
    end else if (c == CH_CLOSE) begin
      r = CLS_CLOSE;
    end else if (op_code(c) != OP_NONE) begin
      r = CLS_OPER;
    end else begin
      r = CLS_UNKNOWN;
    end
    return r;
  endfunction

  function automatic logic [7:0] op_char(input op_e op);
    logic [7:0] r;
    case (op)
      OP_OPEN: r = CH_OPEN;
      OP_ADD:  r = CH_ADD;
      OP_SUB:  r = CH_SUB;
      OP_MUL:  r = CH_MUL;
      OP_DIV:  r = CH_DIV;
      OP_MOD:  r = CH_MOD;
      OP_POW:  r = CH_POW;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] op_prio(input op_e op);
    logic [1:0] r;
    case (op)
      OP_ADD, OP_SUB:         r = 2'd1;
      OP_MUL, OP_DIV, OP_MOD: r = 2'd2;
      OP_POW:                 r = 2'd3;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/i2p_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2p_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/i2p_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_stack
// Operator stack in RAM with a fill count; the top entry is read ahead every
// cycle and a same-cycle push is forwarded past the RAM.
// ----------------------------------------------------------------------------
module i2p_stack import i2p_pkg::*; #(
  parameter  int unsigned StackDepth = STACK_DEPTH_DEF,
  localparam int unsigned CntW       = $clog2(StackDepth + 1),
  localparam int unsigned AddrW      = $clog2(StackDepth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stack_cmd_t      cmd_i,
  output op_e             top_o,
  output logic [CntW-1:0] count_o,
  output logic            full_o
);

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_cnt;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [2:0]       rd_data;
  logic             fwd_v_q, fwd_v_d;
  logic [2:0]       fwd_q;

  assign full_o  = (count_q == CntW'(StackDepth));
  assign wr_en   = cmd_i.push && !full_o;
  assign wr_addr = count_q[AddrW-1:0];

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign rd_cnt  = count_d - CntW'(1);
  assign rd_addr = rd_cnt[AddrW-1:0];
  assign fwd_v_d = wr_en && (wr_addr == rd_addr);

  i2p_ram #(
    .Width(3),
    .Depth(StackDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(cmd_i.code),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      fwd_v_q <= 1'b0;
    end else begin
      count_q <= count_d;
      fwd_v_q <= fwd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= cmd_i.code;
  end

  assign top_o   = op_e'(fwd_v_q ? fwd_q : rd_data);
  assign count_o = count_q;

endmodule

/* rtl/infix_to_postfix_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// One character is taken at a time; the next is accepted once every result of
// the current one has entered the output register. An item passes through an
// accept step, a dispatch step that repeats for each operator popped from the
// stack, and a closing step. The last character of an expression adds a flush
// step that pops the stack until it is empty, and one more closing step when
// any character was emitted for it. The dispatch, flush and closing steps wait
// while the output side stalls. The pop rate is set by the stack RAM, whose
// top entry is read ahead. The stack holds STACK_DEPTH operators; the RAM needs
// no clearing after reset.
module infix_to_postfix_converter_unit import i2p_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_expr_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic [2:0] status_o,
  output logic       run_last_o,
  output logic       expr_done_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAIN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [7:0]      char_q, char_d;
  logic            end_q, end_d;
  cls_e            cls_q, cls_d;
  op_e             op_q, op_d;
  status_e         err_q, err_d;

  logic            pend_v_q, pend_v_d;
  logic [7:0]      pend_char_q, pend_char_d;
  status_e         pend_stat_q, pend_stat_d;

  logic            out_v_q, out_v_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            out_cv_q, out_cv_d;
  status_e         out_stat_q, out_stat_d;
  logic            out_rl_q, out_rl_d;
  logic            out_ed_q, out_ed_d;

  stack_cmd_t      cmd;
  op_e             top;
  logic [CntW-1:0] count;
  logic            full;
  logic            nonempty;
  logic            step;
  logic            emit;
  logic [7:0]      emit_char;
  status_e         note;

  i2p_stack #(
    .StackDepth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .top_o  (top),
    .count_o(count),
    .full_o (full)
  );

  assign nonempty   = (count != '0);
  assign step       = !out_v_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    char_d      = char_q;
    end_d       = end_q;
    cls_d       = cls_q;
    op_d        = op_q;
    err_d       = err_q;
    pend_v_d    = pend_v_q;
    pend_char_d = pend_char_q;
    pend_stat_d = pend_stat_q;
    out_v_d     = out_v_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_cv_d    = out_cv_q;
    out_stat_d  = out_stat_q;
    out_rl_d    = out_rl_q;
    out_ed_d    = out_ed_q;
    cmd         = '{push: 1'b0, pop: 1'b0, clear: 1'b0, code: OP_OPEN};
    emit        = 1'b0;
    emit_char   = char_q;
    note        = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          char_d  = in_char_i;
          end_d   = end_of_expr_i;
          cls_d   = char_class(in_char_i);
          op_d    = op_code(in_char_i);
          state_d = S_MAIN;
        end
      end
      S_MAIN: begin
        if (step) begin
          state_d = end_q ? S_FLUSH : S_FIN;
          case (cls_q)
            CLS_SPACE: ;
            CLS_UNKNOWN: note = ST_UNKNOWN_CHAR;
            CLS_ALNUM: begin
              emit      = 1'b1;
              emit_char = char_q;
            end
            CLS_OPEN: begin
              cmd.push = 1'b1;
              cmd.code = OP_OPEN;
              if (full) note = ST_OVERFLOW;
            end
            CLS_CLOSE: begin
              if (nonempty && top != OP_OPEN) begin
                emit      = 1'b1;
                emit_char = op_char(top);
                cmd.pop   = 1'b1;
                state_d   = S_MAIN;
              end else if (nonempty) begin
                cmd.pop = 1'b1;
              end else begin
                note = ST_UNMATCHED_CLOSE;
              end
            end
            CLS_OPER: begin
              if (nonempty && op_prio(op_q) <= op_prio(top)) begin
                emit      = 1'b1;
                emit_char = op_char(top);
                cmd.pop   = 1'b1;
                state_d   = S_MAIN;
              end else begin
                cmd.push = 1'b1;
                cmd.code = op_q;
                if (full) note = ST_OVERFLOW;
              end
            end
            default: ;
          endcase
        end
      end
      S_FLUSH: begin
        if (step) begin
          if (nonempty) begin
            cmd.pop = 1'b1;
            if (top == OP_OPEN) begin
              note = ST_UNMATCHED_OPEN;
            end else begin
              emit      = 1'b1;
              emit_char = op_char(top);
            end
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (step) begin
          out_v_d = 1'b1;
          out_ed_d = 1'b0;
          if (pend_v_q) begin
            out_char_d = pend_char_q;
            out_cv_d   = 1'b1;
            out_stat_d = pend_stat_q;
            out_rl_d   = !end_q;
            pend_v_d   = 1'b0;
            if (!end_q) state_d = S_IDLE;
          end else begin
            out_char_d = CH_NUL;
            out_cv_d   = 1'b0;
            out_stat_d = err_q;
            out_rl_d   = 1'b1;
            out_ed_d   = end_q;
            state_d    = S_IDLE;
            if (end_q) begin
              cmd.clear = 1'b1;
              err_d     = ST_OK;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (note != ST_OK && err_q == ST_OK) begin
      err_d = note;
    end

    // Hold each emitted character until the next one or the close so the last one can be tagged.
    if (emit) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_char_d = pend_char_q;
        out_cv_d   = 1'b1;
        out_stat_d = pend_stat_q;
        out_rl_d   = 1'b0;
        out_ed_d   = 1'b0;
      end
      pend_v_d    = 1'b1;
      pend_char_d = emit_char;
      pend_stat_d = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      err_q    <= ST_OK;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      err_q    <= err_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    end_q       <= end_d;
    cls_q       <= cls_d;
    op_q        <= op_d;
    pend_char_q <= pend_char_d;
    pend_stat_q <= pend_stat_d;
    out_char_q  <= out_char_d;
    out_cv_q    <= out_cv_d;
    out_stat_q  <= out_stat_d;
    out_rl_q    <= out_rl_d;
    out_ed_q    <= out_ed_d;
  end

  assign out_valid_o  = out_v_q;
  assign out_char_o   = out_char_q;
  assign char_valid_o = out_cv_q;
  assign status_o     = out_stat_q;
  assign run_last_o   = out_rl_q;
  assign expr_done_o  = out_ed_q;

endmodule

/* rtl/i2p_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_port_checks
// Port-level checks for the infix to postfix unit, bound to the top level.
// ----------------------------------------------------------------------------
module i2p_port_checks import i2p_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       char_valid_o,
  input logic [2:0] status_o,
  input logic       run_last_o,
  input logic       expr_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) &&
      $stable(char_valid_o) && $stable(status_o) && $stable(run_last_o) &&
      $stable(expr_done_o))
    else $error("output item changed while stalled");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> out_char_o == CH_NUL)
    else $error("bare item carries a character");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expr_done_o |-> run_last_o && !char_valid_o)
    else $error("expression end is not a bare last item");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_UNMATCHED_OPEN)
    else $error("status code out of range");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one still in work");

endmodule

bind infix_to_postfix_converter_unit i2p_port_checks u_i2p_checker (.*);
